/* rtl/rqsi_pkg.sv */
// -----------------------------------------------------------------------------
// rqsi_pkg: shared types and constants of the ready queue
// Sizes, field widths, item and status codes, controller state and command.
// -----------------------------------------------------------------------------
package rqsi_pkg;

   // queue geometry
   localparam int QUEUE_DEPTH = 64;
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   // field widths
   localparam int ID_W     = 16;
   localparam int PRIO_W   = 8;
   localparam int RT_W     = 16;
   localparam int KEY_W    = 16;
   localparam int STATUS_W = 2;
   localparam int OCC_W    = 7;
   localparam int MODE_W   = 2;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // item kinds
   localparam logic KIND_INSERT = 1'b0;
   localparam logic KIND_POP    = 1'b1;

   // order modes (mode 3 behaves as remaining-time order)
   localparam logic [MODE_W-1:0] MODE_FIFO = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PRIO = 2'd1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_COMPARE,
      ST_UPDATE
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load_item;
      logic compare;
      logic update;
   } dp_cmd_type;

endpackage

/* rtl/rqsi_req_if.sv */
// -----------------------------------------------------------------------------
// rqsi_req_if: request channel of the ready queue
// Valid/ready handshake carrying one insert or pop item per beat.
// -----------------------------------------------------------------------------
interface rqsi_req_if;
   logic                        valid;
   logic                        ready;
   logic                        kind;
   logic [rqsi_pkg::ID_W-1:0]   proc_id;
   logic [rqsi_pkg::PRIO_W-1:0] prio;
   logic [rqsi_pkg::RT_W-1:0]   remaining_time;

   modport source (output valid, kind, proc_id, prio, remaining_time, input ready);
   modport sink   (input valid, kind, proc_id, prio, remaining_time, output ready);
endinterface

/* rtl/rqsi_rsp_if.sv */
// -----------------------------------------------------------------------------
// rqsi_rsp_if: response channel of the ready queue
// Valid/ready handshake carrying one result per beat.
// -----------------------------------------------------------------------------
interface rqsi_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          item_valid;
   logic [rqsi_pkg::ID_W-1:0]     out_proc_id;
   logic [rqsi_pkg::PRIO_W-1:0]   out_prio;
   logic [rqsi_pkg::RT_W-1:0]     out_remaining_time;
   logic [rqsi_pkg::STATUS_W-1:0] status;
   logic [rqsi_pkg::OCC_W-1:0]    occupancy;

   modport source (output valid, item_valid, out_proc_id, out_prio, out_remaining_time,
                   status, occupancy, input ready);
   modport sink   (input valid, item_valid, out_proc_id, out_prio, out_remaining_time,
                   status, occupancy, output ready);
endinterface

/* rtl/ready_queue_sorted_insert.sv */
// After the request beat come compare, then update, which registers the result.
// Update waits for a free output register; only after it is the next request taken.
// The next request is taken while the previous result still waits in the output register.
// Reset (synchronous, active high) empties the queue and sets order_mode to FIFO.
// -----------------------------------------------------------------------------
// ready_queue_sorted_insert: bounded scheduler ready queue
// FIFO or stable sorted insert by priority or remaining time, pop from head,
// with a CSR for the order mode.
// -----------------------------------------------------------------------------
module ready_queue_sorted_insert (
   input  logic                                clock,
   input  logic                                reset,
   rqsi_req_if.sink                            req_ch,
   rqsi_rsp_if.source                          rsp_ch,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [rqsi_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [rqsi_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [rqsi_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   logic [rqsi_pkg::MODE_W-1:0] order_mode_ff, order_mode_in;
   logic                        csr_write, mode_sel;
   rqsi_pkg::dp_cmd_type        cmd;

   // order mode register, byte address 0
   assign csr_pready = 1'b1;
   assign mode_sel   = (csr_paddr[rqsi_pkg::CSR_ADDR_W-1:2] == '0);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      order_mode_in = order_mode_ff;
      if (csr_write && mode_sel) begin
         order_mode_in = csr_pwdata[rqsi_pkg::MODE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         order_mode_ff <= rqsi_pkg::MODE_FIFO;
      end else begin
         order_mode_ff <= order_mode_in;
      end
   end

   assign csr_prdata = mode_sel ? rqsi_pkg::CSR_DATA_W'(order_mode_ff) : '0;

   rqsi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   rqsi_dp u_dp (
      .clock                  (clock),
      .reset                  (reset),
      .cmd                    (cmd),
      .order_mode             (order_mode_ff),
      .req_kind               (req_ch.kind),
      .req_proc_id            (req_ch.proc_id),
      .req_prio               (req_ch.prio),
      .req_remaining_time     (req_ch.remaining_time),
      .rsp_item_valid         (rsp_ch.item_valid),
      .rsp_out_proc_id        (rsp_ch.out_proc_id),
      .rsp_out_prio           (rsp_ch.out_prio),
      .rsp_out_remaining_time (rsp_ch.out_remaining_time),
      .rsp_status             (rsp_ch.status),
      .rsp_occupancy          (rsp_ch.occupancy)
   );

endmodule

/* rtl/rqsi_ctrl.sv */
// -----------------------------------------------------------------------------
// rqsi_ctrl: sequencer of the ready queue
// Steps each item through capture, key compare and cell update, and owns
// the request ready and response valid flags.
// -----------------------------------------------------------------------------
module rqsi_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rqsi_pkg::dp_cmd_type cmd
);

   rqsi_pkg::state_type state_ff, state_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // state and response flag registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rqsi_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      req_ready     = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      // drop the pending result once its beat is taken
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         rqsi_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = rqsi_pkg::ST_COMPARE;
            end
         end
         rqsi_pkg::ST_COMPARE: begin
            cmd.compare = 1'b1;
            state_in    = rqsi_pkg::ST_UPDATE;
         end
         rqsi_pkg::ST_UPDATE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.update   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = rqsi_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rqsi_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

/* rtl/rqsi_dp.sv */
// -----------------------------------------------------------------------------
// rqsi_dp: datapath of the ready queue
// A row of shift cells, head at cell 0, with a key comparator per cell, the
// entry count and the response register.
// -----------------------------------------------------------------------------
module rqsi_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  rqsi_pkg::dp_cmd_type            cmd,
   input  logic [rqsi_pkg::MODE_W-1:0]     order_mode,
   input  logic                            req_kind,
   input  logic [rqsi_pkg::ID_W-1:0]       req_proc_id,
   input  logic [rqsi_pkg::PRIO_W-1:0]     req_prio,
   input  logic [rqsi_pkg::RT_W-1:0]       req_remaining_time,
   output logic                            rsp_item_valid,
   output logic [rqsi_pkg::ID_W-1:0]       rsp_out_proc_id,
   output logic [rqsi_pkg::PRIO_W-1:0]     rsp_out_prio,
   output logic [rqsi_pkg::RT_W-1:0]       rsp_out_remaining_time,
   output logic [rqsi_pkg::STATUS_W-1:0]   rsp_status,
   output logic [rqsi_pkg::OCC_W-1:0]      rsp_occupancy
);

   localparam int DEPTH = rqsi_pkg::QUEUE_DEPTH;

   // captured item
   logic                          kind_ff;
   logic [rqsi_pkg::ID_W-1:0]     id_ff;
   logic [rqsi_pkg::PRIO_W-1:0]   prio_ff;
   logic [rqsi_pkg::RT_W-1:0]     rt_ff;

   // cells
   logic [rqsi_pkg::ID_W-1:0]     cell_id_ff   [DEPTH];
   logic [rqsi_pkg::ID_W-1:0]     cell_id_in   [DEPTH];
   logic [rqsi_pkg::PRIO_W-1:0]   cell_prio_ff [DEPTH];
   logic [rqsi_pkg::PRIO_W-1:0]   cell_prio_in [DEPTH];
   logic [rqsi_pkg::RT_W-1:0]     cell_rt_ff   [DEPTH];
   logic [rqsi_pkg::RT_W-1:0]     cell_rt_in   [DEPTH];

   // compare flags and insert decode
   logic [DEPTH-1:0]              gt_ff, gt_in;
   logic [DEPTH-1:0]              shift_up;

   logic [rqsi_pkg::CNT_W-1:0]    count_ff, count_in;
   logic                          empty, full;
   logic                          do_pop, do_insert;
   logic [rqsi_pkg::KEY_W-1:0]    new_key;

   // response register
   logic                          item_valid_ff, item_valid_in;
   logic [rqsi_pkg::ID_W-1:0]     out_id_ff, out_id_in;
   logic [rqsi_pkg::PRIO_W-1:0]   out_prio_ff, out_prio_in;
   logic [rqsi_pkg::RT_W-1:0]     out_rt_ff, out_rt_in;
   logic [rqsi_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [rqsi_pkg::OCC_W-1:0]    occ_ff, occ_in;

   assign empty     = (count_ff == '0);
   assign full      = (count_ff == rqsi_pkg::CNT_W'(DEPTH));
   assign do_pop    = cmd.update && (kind_ff == rqsi_pkg::KIND_POP) && !empty;
   assign do_insert = cmd.update && (kind_ff == rqsi_pkg::KIND_INSERT) && !full;
   assign new_key   = (order_mode == rqsi_pkg::MODE_PRIO) ?
                      rqsi_pkg::KEY_W'(prio_ff) : rqsi_pkg::KEY_W'(rt_ff);

   // capture the item
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         kind_ff <= req_kind;
         id_ff   <= req_proc_id;
         prio_ff <= req_prio;
         rt_ff   <= req_remaining_time;
      end
   end

   // per-cell compare and update
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      localparam int PREV = (i == 0) ? 0 : i - 1;
      localparam int NEXT = (i == DEPTH - 1) ? i : i + 1;
      localparam logic [DEPTH-1:0] LOW_MASK = (DEPTH'(1) << i) - DEPTH'(1);

      logic [rqsi_pkg::KEY_W-1:0] cell_key;
      logic                       held;

      assign held     = (rqsi_pkg::CNT_W'(i) < count_ff);
      assign cell_key = (order_mode == rqsi_pkg::MODE_PRIO) ?
                        rqsi_pkg::KEY_W'(cell_prio_ff[i]) : rqsi_pkg::KEY_W'(cell_rt_ff[i]);
      assign gt_in[i] = held && (order_mode != rqsi_pkg::MODE_FIFO) && (cell_key > new_key);
      // some earlier cell already holds a greater key
      assign shift_up[i] = |(gt_ff & LOW_MASK);

      always_comb begin
         cell_id_in[i]   = cell_id_ff[i];
         cell_prio_in[i] = cell_prio_ff[i];
         cell_rt_in[i]   = cell_rt_ff[i];
         if (do_pop) begin
            // advance toward the head
            cell_id_in[i]   = cell_id_ff[NEXT];
            cell_prio_in[i] = cell_prio_ff[NEXT];
            cell_rt_in[i]   = cell_rt_ff[NEXT];
         end else if (do_insert) begin
            if (shift_up[i] && (i != 0)) begin
               // make room behind the insert point
               cell_id_in[i]   = cell_id_ff[PREV];
               cell_prio_in[i] = cell_prio_ff[PREV];
               cell_rt_in[i]   = cell_rt_ff[PREV];
            end else if (gt_ff[i] || (count_ff == rqsi_pkg::CNT_W'(i))) begin
               cell_id_in[i]   = id_ff;
               cell_prio_in[i] = prio_ff;
               cell_rt_in[i]   = rt_ff;
            end
         end
      end

      always_ff @(posedge clock) begin
         cell_id_ff[i]   <= cell_id_in[i];
         cell_prio_ff[i] <= cell_prio_in[i];
         cell_rt_ff[i]   <= cell_rt_in[i];
         if (cmd.compare) begin
            gt_ff[i] <= gt_in[i];
         end
      end
   end

   // count and response
   always_comb begin
      count_in      = count_ff;
      item_valid_in = item_valid_ff;
      out_id_in     = out_id_ff;
      out_prio_in   = out_prio_ff;
      out_rt_in     = out_rt_ff;
      status_in     = status_ff;
      occ_in        = occ_ff;
      if (cmd.update) begin
         item_valid_in = 1'b0;
         out_id_in     = '0;
         out_prio_in   = '0;
         out_rt_in     = '0;
         status_in     = rqsi_pkg::STATUS_DONE;
         if (kind_ff == rqsi_pkg::KIND_POP) begin
            if (empty) begin
               status_in = rqsi_pkg::STATUS_EMPTY;
            end else begin
               item_valid_in = 1'b1;
               out_id_in     = cell_id_ff[0];
               out_prio_in   = cell_prio_ff[0];
               out_rt_in     = cell_rt_ff[0];
               count_in      = count_ff - rqsi_pkg::CNT_W'(1);
            end
         end else begin
            if (full) begin
               status_in = rqsi_pkg::STATUS_FULL;
            end else begin
               count_in = count_ff + rqsi_pkg::CNT_W'(1);
            end
         end
         occ_in = rqsi_pkg::OCC_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      item_valid_ff <= item_valid_in;
      out_id_ff     <= out_id_in;
      out_prio_ff   <= out_prio_in;
      out_rt_ff     <= out_rt_in;
      status_ff     <= status_in;
      occ_ff        <= occ_in;
   end

   assign rsp_item_valid         = item_valid_ff;
   assign rsp_out_proc_id        = out_id_ff;
   assign rsp_out_prio           = out_prio_ff;
   assign rsp_out_remaining_time = out_rt_ff;
   assign rsp_status             = status_ff;
   assign rsp_occupancy          = occ_ff;

endmodule

/* rtl/rqsi_checker.sv */
// -----------------------------------------------------------------------------
// rqsi_checker: port-level checks of the ready queue
// Watches the response channel for handshake and result consistency.
// -----------------------------------------------------------------------------
module rqsi_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic                            rsp_item_valid,
   input  logic [rqsi_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [rqsi_pkg::OCC_W-1:0]      rsp_occupancy
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_occupancy) && $stable(rsp_status))
      else $error("rsp beat dropped or changed while stalled");

   // a returned entry always comes with done status
   a_item_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item_valid |-> rsp_status == rqsi_pkg::STATUS_DONE)
      else $error("popped entry with non-done status");

   // empty pop leaves an empty queue and no entry
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rqsi_pkg::STATUS_EMPTY |->
         rsp_occupancy == '0 && !rsp_item_valid)
      else $error("empty status with entries held");

   // a dropped insert means the queue is full
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == rqsi_pkg::STATUS_FULL |->
         rsp_occupancy == rqsi_pkg::OCC_W'(rqsi_pkg::QUEUE_DEPTH))
      else $error("full status below capacity");

endmodule

bind ready_queue_sorted_insert rqsi_checker u_rqsi_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_item_valid (rsp_ch.item_valid),
   .rsp_status     (rsp_ch.status),
   .rsp_occupancy  (rsp_ch.occupancy)
);
